[sv/fen_position_parser_assert.svh]
// ----------------------------------------------------------------------------
// fen position parser assertion macros
// shorthand for the clocked, reset-gated properties used by the checker
// ----------------------------------------------------------------------------
`ifndef FEN_POSITION_PARSER_ASSERT_SVH
`define FEN_POSITION_PARSER_ASSERT_SVH

// condition must hold at every edge out of reset
`define FPP_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define FPP_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fpp_pkg.sv]
// ----------------------------------------------------------------------------
// fpp_pkg
// character codes, piece codes and the decoded character type shared by the
// fen position parser modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpp_pkg;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChW     = 8'h77;

  localparam logic [4:0] SideWhite = 5'd8;
  localparam logic [4:0] SideBlack = 5'd16;

  localparam logic [7:0] EpNone = 8'hFF;

  localparam logic [3:0] CastleWk = 4'b0001;
  localparam logic [3:0] CastleWq = 4'b0010;
  localparam logic [3:0] CastleBk = 4'b0100;
  localparam logic [3:0] CastleBq = 4'b1000;

  typedef struct packed {
    logic       is_nul;
    logic       is_digit;
    logic       is_slash;
    logic       is_space;
    logic       is_dash;
    logic       is_w;
    logic [3:0] castle;
    logic [4:0] piece;
  } char_class_t;

  function automatic logic [4:0] piece_code(input logic [7:0] c);
    logic [4:0] p;
    case (c)
      8'h70:   p = 5'd18;  // p
      8'h72:   p = 5'd22;  // r
      8'h6E:   p = 5'd19;  // n
      8'h62:   p = 5'd21;  // b
      8'h71:   p = 5'd23;  // q
      8'h6B:   p = 5'd20;  // k
      8'h50:   p = 5'd9;   // P
      8'h52:   p = 5'd14;  // R
      8'h4E:   p = 5'd11;  // N
      8'h42:   p = 5'd13;  // B
      8'h51:   p = 5'd15;  // Q
      8'h4B:   p = 5'd12;  // K
      default: p = 5'd0;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] castle_code(input logic [7:0] c);
    logic [3:0] b;
    case (c)
      8'h4B:   b = CastleWk;
      8'h51:   b = CastleWq;
      8'h6B:   b = CastleBk;
      8'h71:   b = CastleBq;
      default: b = 4'b0000;
    endcase
    return b;
  endfunction

endpackage

[sv/fpp_char_decode.sv]
// ----------------------------------------------------------------------------
// fpp_char_decode
// classifies one position-string character and looks up its piece code
// and castling right
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpp_char_decode (
  input  logic [7:0]          ch_i,
  output fpp_pkg::char_class_t cls_o
);

  always_comb begin
    cls_o          = '0;
    cls_o.is_nul   = (ch_i == fpp_pkg::ChNul);
    cls_o.is_digit = (ch_i >= fpp_pkg::ChOne) && (ch_i <= fpp_pkg::ChEight);
    cls_o.is_slash = (ch_i == fpp_pkg::ChSlash);
    cls_o.is_space = (ch_i == fpp_pkg::ChSpace);
    cls_o.is_dash  = (ch_i == fpp_pkg::ChDash);
    cls_o.is_w     = (ch_i == fpp_pkg::ChW);
    cls_o.castle   = fpp_pkg::castle_code(ch_i);
    cls_o.piece    = fpp_pkg::piece_code(ch_i);
  end

endmodule

[sv/fen_position_parser.sv]
// ----------------------------------------------------------------------------
// fen_position_parser
// streaming parser of a fen position string, one character per beat
// ----------------------------------------------------------------------------
// Takes one character per cycle while out_ready_i does not stall the result
// register: a character sits in the input register while the phase logic
// updates the parse state, and its result, if any, is then registered in the
// result register. Each piece letter of the placement field gives a board
// write at its 0x88 square; the end of the en-passant field gives one
// summary beat with side to move, castling rights and en-passant square.
// A NUL character restarts the parse and clears castling rights.
`timescale 1ns / 1ps

module fen_position_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        ch_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_summary_o,
  output logic [6:0]        square_o,
  output logic [4:0]        piece_o,
  output logic [4:0]        side_o,
  output logic [3:0]        castling_o,
  output logic signed [7:0] ep_square_o
);

  typedef enum logic [2:0] {
    PhPlace,
    PhSide,
    PhSkip,
    PhCastle,
    PhEpFile,
    PhEpRank,
    PhDone
  } phase_e;

  // input stage
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       out_valid_q;
  logic       advance;
  logic       proc;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign proc       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q <= ch_i;
    end
  end

  fpp_pkg::char_class_t cls;

  fpp_char_decode u_fpp_char_decode (
    .ch_i  (ch_q),
    .cls_o (cls)
  );

  // parse state
  phase_e     phase_q, phase_d;
  logic [7:0] sq_q, sq_d;
  logic [4:0] side_q, side_d;
  logic [3:0] castle_q, castle_d;
  logic [2:0] file_q, file_d;

  // result register
  logic       is_summary_q, is_summary_d;
  logic [6:0] square_q, square_d;
  logic [4:0] piece_q, piece_d;
  logic [4:0] rside_q, rside_d;
  logic [3:0] rcastle_q, rcastle_d;
  logic [7:0] ep_q, ep_d;
  logic       res_valid;

  logic [3:0] step;
  logic [8:0] sum;
  logic [2:0] row;

  always_comb begin
    if (cls.is_digit) begin
      step = ch_q[3:0];
    end else if (cls.is_slash) begin
      step = 4'd8;
    end else begin
      step = 4'd1;
    end
    sum = {1'b0, sq_q} + {5'd0, step};
    row = 3'd0 - ch_q[2:0];
  end

  always_comb begin
    phase_d      = phase_q;
    sq_d         = sq_q;
    side_d       = side_q;
    castle_d     = castle_q;
    file_d       = file_q;
    res_valid    = 1'b0;
    is_summary_d = 1'b0;
    square_d     = '0;
    piece_d      = '0;
    rside_d      = '0;
    rcastle_d    = '0;
    ep_d         = '0;
    if (cls.is_nul) begin
      phase_d  = PhPlace;
      sq_d     = '0;
      castle_d = '0;
    end else begin
      case (phase_q)
        PhPlace: begin
          if (cls.is_space) begin
            phase_d = PhSide;
          end else begin
            sq_d = sum[8] ? 8'hFF : sum[7:0];
            if (!cls.is_digit && !cls.is_slash && !sq_q[7]) begin
              res_valid = 1'b1;
              square_d  = sq_q[6:0];
              piece_d   = cls.piece;
            end
          end
        end
        PhSide: begin
          side_d  = cls.is_w ? fpp_pkg::SideWhite : fpp_pkg::SideBlack;
          phase_d = PhSkip;
        end
        PhSkip: begin
          phase_d = PhCastle;
        end
        PhCastle: begin
          if (cls.is_space) begin
            phase_d = PhEpFile;
          end else begin
            castle_d = castle_q | cls.castle;
          end
        end
        PhEpFile: begin
          if (cls.is_dash) begin
            phase_d      = PhDone;
            res_valid    = 1'b1;
            is_summary_d = 1'b1;
            rside_d      = side_q;
            rcastle_d    = castle_q;
            ep_d         = fpp_pkg::EpNone;
          end else begin
            file_d  = ch_q[2:0] - 3'd1;
            phase_d = PhEpRank;
          end
        end
        PhEpRank: begin
          phase_d      = PhDone;
          res_valid    = 1'b1;
          is_summary_d = 1'b1;
          rside_d      = side_q;
          rcastle_d    = castle_q;
          ep_d         = {1'b0, row, 1'b0, file_q};
        end
        default: begin
          phase_d = PhDone;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhPlace;
      sq_q        <= '0;
      side_q      <= fpp_pkg::SideBlack;
      castle_q    <= '0;
      file_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (proc) begin
        phase_q  <= phase_d;
        sq_q     <= sq_d;
        side_q   <= side_d;
        castle_q <= castle_d;
        file_q   <= file_d;
      end
      if (advance) begin
        out_valid_q <= proc && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      is_summary_q <= is_summary_d;
      square_q     <= square_d;
      piece_q      <= piece_d;
      rside_q      <= rside_d;
      rcastle_q    <= rcastle_d;
      ep_q         <= ep_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_summary_o = is_summary_q;
  assign square_o     = square_q;
  assign piece_o      = piece_q;
  assign side_o       = rside_q;
  assign castling_o   = rcastle_q;
  assign ep_square_o  = $signed(ep_q);

endmodule

[sv/fpp_checker.sv]
// ----------------------------------------------------------------------------
// fpp_checker
// port-level checks on the fen position parser result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fen_position_parser_assert.svh"

module fpp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              is_summary_o,
  input logic [6:0]        square_o,
  input logic [4:0]        piece_o,
  input logic [4:0]        side_o,
  input logic [3:0]        castling_o,
  input logic signed [7:0] ep_square_o
);

  logic        summary_beat;
  logic        board_beat;
  logic        summary_ok;
  logic        board_ok;
  logic        ep_ok;
  logic        out_stall;
  logic [29:0] beat;

  assign summary_beat = out_valid_o && is_summary_o;
  assign board_beat   = out_valid_o && !is_summary_o;
  assign out_stall    = out_valid_o && !out_ready_i;

  assign summary_ok = (square_o == 7'd0) && (piece_o == 5'd0) &&
                      ((side_o == fpp_pkg::SideWhite) || (side_o == fpp_pkg::SideBlack));
  assign board_ok   = (side_o == 5'd0) && (castling_o == 4'd0) && (ep_square_o == 8'sd0);
  assign ep_ok      = (ep_square_o[7] || !ep_square_o[3]) &&
                      (!ep_square_o[7] || (&ep_square_o[6:0]));
  assign beat       = {is_summary_o, square_o, piece_o, side_o, castling_o, ep_square_o};

  `FPP_ASSERT_IMPLIES(a_summary_fields, clk_i, rst_ni, summary_beat, summary_ok, "bad summary")

  `FPP_ASSERT_IMPLIES(a_board_fields, clk_i, rst_ni, board_beat, board_ok, "bad board write")

  `FPP_ASSERT_IMPLIES(a_ep_shape, clk_i, rst_ni, summary_beat, ep_ok, "en passant off board")

  `FPP_ASSERT_NEXT(a_out_hold_valid, clk_i, rst_ni, out_stall, out_valid_o, "stalled beat dropped")

  `FPP_ASSERT_NEXT(a_out_hold_data, clk_i, rst_ni, out_stall, $stable(beat), "stalled beat changed")

endmodule

bind fen_position_parser fpp_checker u_fpp_checker (.*);
